// File: sv/binary_mask_boundary_extract_macros.svh
// Assertion macros shared by the boundary extraction RTL.
`ifndef BINARY_MASK_BOUNDARY_EXTRACT_MACROS_SVH
`define BINARY_MASK_BOUNDARY_EXTRACT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BMBE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define BMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bmbe_pkg.sv
// Package: types, register codes and sizes for the mask boundary extractor.
package bmbe_pkg;

	// Fixed field widths
	localparam int ALPHA_W = 8;
	localparam int CFG_W   = 11;
	localparam int POS_W   = 10;
	localparam int LINE_W  = 10;
	localparam int CFG_IDX_W = 2;

	// Default line store depth and frame height
	localparam int MAX_LINE_DEF  = 1024;
	localparam int MAX_LINES_DEF = 1024;

	// Smallest usable line length / frame height
	localparam int MIN_SIZE = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_TOTAL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0]   LINE_LENGTH_RST = 11'd1024;
	localparam logic [CFG_W-1:0]   LINE_TOTAL_RST  = 11'd1024;
	localparam logic [ALPHA_W-1:0] THRESHOLD_RST   = 8'd128;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               frame_start;
	} bmbe_in_t;

	typedef struct packed {
		logic              edge_res;
		logic [POS_W-1:0]  pos_in_line;
		logic [LINE_W-1:0] line_index;
	} bmbe_out_t;

endpackage

// File: sv/binary_mask_boundary_extract.sv
// Top level: streaming 4-neighbour boundary extraction of a thresholded alpha mask.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | input     | in_valid / in_stall    | in_data  (alpha, frame_start)
//  out     | output    | out_valid / out_stall  | out_data (edge_res, pos_in_line, line_index)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel per clock while in_stall is low. A pixel is read from both line stores in the cycle it is
// taken and written back in the cycle after; a bypass covers a repeat of the same address.
// A result is formed in stage 1 and passes through a three-entry output queue.
// After reset a clearing pass over every address zeroes the line stores; in_stall is
// held high meanwhile. Outside that pass, in_stall rises only when the output queue would fill.
`include "binary_mask_boundary_extract_macros.svh"

module binary_mask_boundary_extract #(
	parameter int MAX_LINE  = bmbe_pkg::MAX_LINE_DEF,
	parameter int MAX_LINES = bmbe_pkg::MAX_LINES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bmbe_pkg::bmbe_in_t               in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bmbe_pkg::bmbe_out_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmbe_pkg::CFG_W-1:0]       cfg_data
);
	import bmbe_pkg::*;

	localparam int AW  = $clog2(MAX_LINE);
	localparam int LAW = $clog2(MAX_LINES);
	localparam int CW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
	localparam int LCW = (LAW + 1 > CFG_W) ? LAW + 1 : CFG_W;
	localparam int FIFO_DEPTH = 3;

	// Configuration registers
	logic [CFG_W-1:0]   line_length_q;
	logic [CFG_W-1:0]   line_total_q;
	logic [ALPHA_W-1:0] alpha_threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q     <= LINE_LENGTH_RST;
			line_total_q      <= LINE_TOTAL_RST;
			alpha_threshold_q <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINE_LENGTH:     line_length_q     <= cfg_data;
				REG_LINE_TOTAL:      line_total_q      <= cfg_data;
				REG_ALPHA_THRESHOLD: alpha_threshold_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped frame geometry
	logic [CW-1:0]  len_c;
	logic [LCW-1:0] tot_c;

	always_comb begin
		if (CW'(line_length_q) < CW'(MIN_SIZE))
			len_c = CW'(MIN_SIZE);
		else if (CW'(line_length_q) > CW'(MAX_LINE))
			len_c = CW'(MAX_LINE);
		else
			len_c = CW'(line_length_q);
		if (LCW'(line_total_q) < LCW'(MIN_SIZE))
			tot_c = LCW'(MIN_SIZE);
		else if (LCW'(line_total_q) > LCW'(MAX_LINES))
			tot_c = LCW'(MAX_LINES);
		else
			tot_c = LCW'(line_total_q);
	end

	// Control state
	logic           clr_q;
	logic [AW-1:0]  clr_addr_q;
	logic [AW-1:0]  pos_q;
	logic [LAW-1:0] line_q;
	logic [3:0]     win_q;
	logic [1:0]     cnt_q;
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;

	// Stage 1 registers
	logic           valid_s1;
	logic [AW-1:0]  p_s1;
	logic [LAW-1:0] l_s1;
	logic           cur_s1;
	logic           emit_s1;
	logic           inner_s1;
	logic           hit_s1;
	logic           byp_prev_s1;
	logic           byp_prev2_s1;
	logic           rd_prev_s1;
	logic           rd_prev2_s1;

	logic accept;
	logic push;
	logic pop;

	assign accept = in_valid && !in_stall;

	// Position of the incoming pixel and the counters that follow it
	logic [AW-1:0]  p0;
	logic [LAW-1:0] l0;
	logic           wrap0;
	logic [AW-1:0]  p_cur;
	logic [LCW-1:0] l1w;
	logic [LAW-1:0] l_cur;
	logic [CW-1:0]  pn;
	logic [LCW-1:0] ln;
	logic [AW-1:0]  pos_nxt;
	logic [LAW-1:0] line_nxt;

	always_comb begin
		p0    = in_data.frame_start ? '0 : pos_q;
		l0    = in_data.frame_start ? '0 : line_q;
		wrap0 = CW'(p0) >= len_c;
		p_cur = wrap0 ? '0 : p0;
		l1w   = wrap0 ? LCW'(l0) + LCW'(1) : LCW'(l0);
		l_cur = (l1w >= tot_c) ? '0 : l1w[LAW-1:0];
		pn    = CW'(p_cur) + CW'(1);
		ln    = LCW'(l_cur) + LCW'(1);
		if (pn >= len_c) begin
			pos_nxt  = '0;
			line_nxt = (ln >= tot_c) ? '0 : ln[LAW-1:0];
		end else begin
			pos_nxt  = pn[AW-1:0];
			line_nxt = l_cur;
		end
	end

	// Stage 1 neighbour bits, with bypass of the write made as this pixel was read
	logic right_old;
	logic up_old;
	logic edge_bit;

	always_comb begin
		right_old = hit_s1 ? byp_prev_s1 : rd_prev_s1;
		up_old    = hit_s1 ? byp_prev2_s1 : rd_prev2_s1;
		edge_bit  = inner_s1 && win_q[1] && !(win_q[0] && win_q[2] && win_q[3] && right_old);
	end

	// Line store write port: clearing pass, then stage 1 write-back
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic          wd_prev;
	logic          wd_prev2;

	always_comb begin
		mem_we   = clr_q || valid_s1;
		mem_wa   = clr_q ? clr_addr_q : p_s1;
		wd_prev  = clr_q ? 1'b0 : cur_s1;
		wd_prev2 = clr_q ? 1'b0 : right_old;
	end

	// Line stores
	logic mem_prev  [MAX_LINE];
	logic mem_prev2 [MAX_LINE];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_prev[mem_wa]  <= wd_prev;
			mem_prev2[mem_wa] <= wd_prev2;
		end
		if (accept) begin
			rd_prev_s1  <= mem_prev[p_cur];
			rd_prev2_s1 <= mem_prev2[p_cur];
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1         <= p_cur;
			l_s1         <= l_cur;
			cur_s1       <= in_data.alpha > alpha_threshold_q;
			emit_s1      <= (p_cur != '0) && (l_cur != '0);
			inner_s1     <= (AW'(p_cur) >= AW'(2)) && (LAW'(l_cur) >= LAW'(2));
			hit_s1       <= valid_s1 && (p_s1 == p_cur);
			byp_prev_s1  <= cur_s1;
			byp_prev2_s1 <= right_old;
		end
	end

	// Counters, window, clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			pos_q      <= '0;
			line_q     <= '0;
			win_q      <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MAX_LINE - 1))
					clr_q <= 1'b0;
			end
			valid_s1 <= accept;
			if (accept) begin
				pos_q  <= pos_nxt;
				line_q <= line_nxt;
			end
			if (valid_s1)
				win_q <= {up_old, win_q[1], right_old, cur_s1};
		end
	end

	// Output queue
	bmbe_out_t fifo_q [FIFO_DEPTH];
	bmbe_out_t res;

	always_comb begin
		res.edge_res    = edge_bit;
		res.pos_in_line = POS_W'(p_s1 - AW'(1));
		res.line_index  = LINE_W'(l_s1 - LAW'(1));
	end

	assign push      = valid_s1 && emit_s1;
	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_data  = fifo_q[rd_ptr_q];
	assign in_stall  = clr_q || ((3'(cnt_q) + 3'(push)) >= 3'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Checks
	`BMBE_ASSERT_NOW(a_no_take_in_clear, clr_q, !accept, "pixel taken during clearing pass")
	`BMBE_ASSERT_NOW(a_queue_room, push, cnt_q != 2'd3, "result pushed into a full queue")
	`BMBE_ASSERT_NOW(a_emit_off_border, push, (p_s1 != '0) && (l_s1 != '0),
		"result emitted for line 0 or position 0 input")
	`BMBE_ASSERT_NEXT(a_stage1_follows, accept, valid_s1, "taken pixel missing from stage 1")

endmodule

// File: dv/testbench.sv
// Testbench for the mask boundary extractor: directed and random frames, local predictor.
module testbench;
	import bmbe_pkg::*;

	// Index with no register behind it: writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES   = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX    = 40;
	localparam int RUN_LIMIT     = 2_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	bmbe_in_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	bmbe_out_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Predictor state: two mask line stores, neighbour window, scan position
	bit                   mask_row_prev [MAX_LINE_DEF];
	bit                   mask_row_prev2 [MAX_LINE_DEF];
	bit [3:0]             nbr_window;
	int unsigned          pix_pos;
	int unsigned          pix_line;
	logic [CFG_W-1:0]     len_reg;
	logic [CFG_W-1:0]     tot_reg;
	logic [ALPHA_W-1:0]   thr_reg;

	bmbe_out_t            expected_marks [$];
	bmbe_out_t            oldest_mark;
	int unsigned          fail_count;
	int unsigned          pixels_sent;
	bit                   tx_idle_on;
	bit                   rx_idle_on;
	bit                   hold_off_req;

	binary_mask_boundary_extract dut (.*);

	always #1 clk = ~clk;

	function automatic int unsigned size_in_use(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int unsigned frame_pixels();
		return size_in_use(len_reg, MAX_LINE_DEF) * size_in_use(tot_reg, MAX_LINES_DEF);
	endfunction

	// Takes one pixel: queues the decision for the pixel one line up and one position left
	function automatic void predict_boundary(logic [ALPHA_W-1:0] a, logic fs);
		int unsigned len;
		int unsigned tot;
		int unsigned p;
		int unsigned l;
		bit          cur;
		bit          right_old;
		bit          up_old;
		bmbe_out_t   res;
		len = size_in_use(len_reg, MAX_LINE_DEF);
		tot = size_in_use(tot_reg, MAX_LINES_DEF);
		if (fs) begin
			pix_pos = 0;
			pix_line = 0;
		end
		// position may sit beyond a length that has just shrunk
		if (pix_pos >= len) begin
			pix_pos = 0;
			pix_line++;
		end
		if (pix_line >= tot)
			pix_line = 0;
		p = pix_pos;
		l = pix_line;
		cur = a > thr_reg;
		right_old = mask_row_prev[p];
		up_old = mask_row_prev2[p];
		if (p >= 1 && l >= 1) begin
			res.edge_res = 1'b0;
			// off the border: centre set and any of the four neighbours clear
			if (p >= 2 && l >= 2)
				res.edge_res = nbr_window[1] &&
					!(nbr_window[0] && nbr_window[2] && nbr_window[3] && right_old);
			res.pos_in_line = POS_W'(p - 1);
			res.line_index = LINE_W'(l - 1);
			expected_marks = {expected_marks, res};
		end
		// window: up, left, centre, down
		nbr_window = {up_old, nbr_window[1], right_old, cur};
		mask_row_prev2[p] = right_old;
		mask_row_prev[p] = cur;
		pix_pos = p + 1;
		if (pix_pos >= len) begin
			pix_pos = 0;
			pix_line = l + 1;
			if (pix_line >= tot)
				pix_line = 0;
		end
	endfunction

	// Alpha above the threshold with the given percentage, else at or below it
	function automatic logic [ALPHA_W-1:0] pick_alpha(int unsigned dense);
		if ($urandom_range(0, 99) < dense)
			return (thr_reg == 8'hFF) ? 8'hFF : ALPHA_W'($urandom_range(thr_reg + 1, 255));
		return ALPHA_W'($urandom_range(0, thr_reg));
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		if ($urandom_range(0, 7) == 0)
			return CFG_W'($urandom_range(0, 2));
		return CFG_W'($urandom_range(3, 12));
	endfunction

	// One pixel transfer; valid stays high unless a sender gap follows
	task automatic send_pixel(logic [ALPHA_W-1:0] a, logic fs);
		in_valid <= 1'b1;
		in_data <= '{alpha: a, frame_start: fs};
		do @(posedge clk); while (in_stall);
		predict_boundary(a, fs);
		pixels_sent++;
		if (tx_idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_run(int unsigned dense, int unsigned count, int unsigned noise_pct,
			bit with_start);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(pick_alpha(dense),
				(i == 0 && with_start) || ($urandom_range(0, 99) < noise_pct));
	endtask

	// Let the block empty out, including pixels that give no result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_marks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LINE_LENGTH:     len_reg = val;
			REG_LINE_TOTAL:      tot_reg = val;
			REG_ALPHA_THRESHOLD: thr_reg = val[ALPHA_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [CFG_W-1:0] len, logic [CFG_W-1:0] tot,
			logic [ALPHA_W-1:0] thr);
		wait_drained();
		write_reg(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_LINE_LENGTH, len);
		write_reg(REG_LINE_TOTAL, tot);
		write_reg(REG_ALPHA_THRESHOLD, {3'($urandom_range(0, 7)), thr});
		cfg_valid <= 1'b0;
	endtask

	// Reset sizes, no frame start: first line only, so nothing may come out
	task automatic test_reset_defaults();
		send_run(70, 30, 0, 0);
	endtask

	// 3x3 frames: solid, one clear neighbour at the threshold, clear centre
	task automatic test_window_cases();
		logic [ALPHA_W-1:0] a;
		set_config(3, 3, 128);
		for (int f = 0; f < 3; f++) begin
			for (int i = 0; i < 9; i++) begin
				a = (f == 0) ? 8'd129 : 8'd255;
				if (f == 1 && i == 5)
					a = 8'd128;
				if (f == 2 && i == 4)
					a = 8'd0;
				send_pixel(a, i == 0);
			end
		end
	endtask

	// Shrink length and height mid-frame so the position wraps before the next pixel
	task automatic test_shrunk_size();
		set_config(16, 8, 100);
		send_run(70, 40, 0, 1);
		set_config(5, 3, 100);
		send_run(70, 20, 0, 0);
	endtask

	// Length clamped to the line store depth, height clamped up to the minimum
	task automatic test_wide_frame();
		set_config(2047, 0, 0);
		send_run(90, 40, 0, 1);
	endtask

	// Height clamped to the maximum, shortest lines: first lines of the frame
	task automatic test_tall_frame();
		set_config(0, 2047, 200);
		send_run(60, 60, 0, 1);
	endtask

	// Receiver holds off long enough for the block to stall its input
	task automatic test_hold_off();
		set_config(8, 6, ALPHA_W'($urandom_range(0, 255)));
		tx_idle_on = 1'b0;
		hold_off_req = 1'b1;
		send_run(80, 96, 0, 1);
		tx_idle_on = 1'b1;
	endtask

	// Sender stops until every result is back, then carries on within the frame
	task automatic test_sender_pause();
		set_config(6, 5, 255);
		send_run(50, 20, 0, 1);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_marks.size() != 0);
		send_run(50, 30, 0, 0);
	endtask

	// Mostly whole frames, some cut short, some with stray frame starts
	task automatic test_random_frames();
		int unsigned first;
		int unsigned dense;
		int unsigned full;
		int unsigned kind;
		first = pixels_sent;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (pixels_sent - first < 400) begin
			set_config(pick_size(), pick_size(), ALPHA_W'($urandom_range(0, 255)));
			dense = $urandom_range(0, 3) * 30 + 8;
			repeat ($urandom_range(2, 4)) begin
				full = frame_pixels();
				kind = $urandom_range(0, 9);
				if (kind < 7)
					send_run(dense, full, 0, 1);
				else if (kind < 9)
					send_run(dense, $urandom_range(1, full - 1), 0, 1);
				else
					send_run(dense, full, 4, 0);
			end
		end
	endtask

	task automatic test_no_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (3) begin
			set_config(CFG_W'($urandom_range(3, 8)), CFG_W'($urandom_range(3, 6)),
				ALPHA_W'($urandom_range(0, 255)));
			send_run(60, frame_pixels(), 0, 1);
		end
	endtask

	task automatic compare_field(string field, logic [LINE_W-1:0] want, logic [LINE_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_MAX)
				$display("%0t: %s expected %0d got %0d (line %0d pos %0d)", $time, field,
					want, got, oldest_mark.line_index, oldest_mark.pos_in_line);
		end
	endtask

	// Receiver: random stall bursts, and the long hold when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Result check against the oldest outstanding decision
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_marks.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: result with none expected, got %p", $time, out_data);
			end else begin
				oldest_mark = expected_marks.pop_front();
				compare_field("edge_res", LINE_W'(oldest_mark.edge_res), LINE_W'(out_data.edge_res));
				compare_field("pos_in_line", oldest_mark.pos_in_line, out_data.pos_in_line);
				compare_field("line_index", oldest_mark.line_index, out_data.line_index);
			end
		end
	end

	initial begin
		#RUN_LIMIT;
		$display("testbench failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LINE_LENGTH;
		cfg_data = '0;
		len_reg = LINE_LENGTH_RST;
		tot_reg = LINE_TOTAL_RST;
		thr_reg = THRESHOLD_RST;
		nbr_window = '0;
		pix_pos = 0;
		pix_line = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_off_req = 1'b0;
		fail_count = 0;
		pixels_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_window_cases();
		test_shrunk_size();
		test_wide_frame();
		test_tall_frame();
		test_hold_off();
		test_sender_pause();
		test_random_frames();
		test_no_idle();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		fail_count += expected_marks.size();
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
